>>> hw/rtl/gpm_pkg.sv
// ----------------------------------------------------------------------------
// gpm_pkg: shared types and constants of the greedy pair matcher
// Field widths, op and register codes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package gpm_pkg;

  localparam int MAX_CANDIDATES_DEF = 64;
  localparam int MAX_PAIRS_DEF      = 1024;
  localparam int HASH_BITS_DEF      = 48;

  localparam int HASH_PORT_W = 48;
  localparam int DIST_W      = 24;
  localparam int IDX_W       = 6;
  localparam int KIND_W      = 3;
  localparam int TOL_W       = 24;
  localparam int FRAC_W      = 16;
  localparam int CONF_W      = 17;
  localparam int DIVN_W      = TOL_W + FRAC_W;
  localparam int KEY_W       = DIST_W + 2 * IDX_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TOL_W-1:0]  TOL_RESET       = 24'd100;
  localparam logic [KIND_W-1:0] KIND_POINT_LAST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_LAST  = 3'd3;

  typedef enum logic [1:0] {
    OP_LOAD_REMOVED = 2'd0,
    OP_LOAD_ADDED   = 2'd1,
    OP_LOAD_PAIR    = 2'd2,
    OP_RUN          = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_TOL = 2'd0,
    REG_LINE_TOL  = 2'd1,
    REG_AREA_TOL  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_ACC,
    S_ACC2,
    S_SORT,
    S_ADDR,
    S_DIVST,
    S_DIV,
    S_EMIT,
    S_EMPTY
  } state_t;

endpackage

>>> hw/rtl/gpm_ram.sv
// ----------------------------------------------------------------------------
// gpm_ram: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gpm_ram #(
  parameter int W  = 8,
  parameter int D  = 4,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/gpm_div.sv
// ----------------------------------------------------------------------------
// gpm_div: radix-2 restoring divider
// Produces one quotient bit per cycle; the low bits of the quotient come out.
// ----------------------------------------------------------------------------
module gpm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gpm_pkg::DIVN_W-1:0] num,
  input  logic [gpm_pkg::TOL_W-1:0]  den,
  output logic                       busy,
  output logic [gpm_pkg::CONF_W-1:0] quo
);

  localparam int NW    = gpm_pkg::DIVN_W;
  localparam int DW    = gpm_pkg::TOL_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [NW-1:0]    sh;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      rem2;
  logic [DW:0]      diff;
  logic             ge;

  always_comb begin
    rem2 = {rem, sh[NW-1]};
    diff = rem2 - {1'b0, den};
    ge   = (rem2 >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NW);
      rem  <= '0;
      sh   <= num;
    end else if (busy) begin
      // shift in one quotient bit as one dividend bit leaves
      rem <= ge ? diff[DW-1:0] : rem2[DW-1:0];
      sh  <= {sh[NW-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = sh[gpm_pkg::CONF_W-1:0];

endmodule

>>> hw/rtl/greedy_pair_matcher.sv
// ----------------------------------------------------------------------------
// greedy_pair_matcher: greedy one-to-one matching by ascending pair distance
//
// Input channel (in_valid/in_stall) carries load ops and the run op. Loads
// of removed candidates, added candidates and scored pairs are accepted
// while idle; loads beyond capacity are dropped. A run stalls the input
// until the last result of the run has been moved into the output register.
// A run first scans the pair store once per match plus one final scan.
// Emitting then scans the match buffer once per result and runs the shared
// restoring divider for the confidence; the pair-store read port and the
// divider bound the run time.
// Output channel (out_valid/out_stall) is one output register; a stalled
// transfer holds the register and the sequencer waits. A run with no match
// gives one transfer with valid_pair low and last high.
// Configuration (cfg_we, cfg_index, cfg_data) writes the three tolerances.
// Reset clears the load counts, used maps and sequencer; all tolerances
// return to 100. Store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module greedy_pair_matcher #(
  parameter int MAX_CANDIDATES = gpm_pkg::MAX_CANDIDATES_DEF,
  parameter int MAX_PAIRS      = gpm_pkg::MAX_PAIRS_DEF,
  parameter int HASH_BITS      = gpm_pkg::HASH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gpm_pkg::TOL_W-1:0]       cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [gpm_pkg::KIND_W-1:0]      geom_kind,
  input  logic [gpm_pkg::HASH_PORT_W-1:0] entry_hash,
  input  logic [gpm_pkg::DIST_W-1:0]      distance,
  input  logic [gpm_pkg::IDX_W-1:0]       removed_idx,
  input  logic [gpm_pkg::IDX_W-1:0]       added_idx,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            valid_pair,
  output logic [gpm_pkg::HASH_PORT_W-1:0] removed_hash_out,
  output logic [gpm_pkg::HASH_PORT_W-1:0] added_hash_out,
  output logic [gpm_pkg::DIST_W-1:0]      match_distance,
  output logic [gpm_pkg::CONF_W-1:0]      confidence,
  output logic                            last
);

  localparam int HW     = (HASH_BITS < gpm_pkg::HASH_PORT_W) ? HASH_BITS
                                                             : gpm_pkg::HASH_PORT_W;
  localparam int CIDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CCNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int PIDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PCNT_W = $clog2(MAX_PAIRS + 1);
  localparam int KW     = gpm_pkg::KIND_W;
  localparam int DW     = gpm_pkg::DIST_W;
  localparam int IW     = gpm_pkg::IDX_W;
  localparam int RW     = HW + KW;              // removed entry: kind, hash
  localparam int MW     = HW + KW + IW + DW;    // match entry: hash, kind, added, dist

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  gpm_pkg::state_t state, state_next;

  logic [gpm_pkg::TOL_W-1:0] point_tol, line_tol, area_tol;
  logic [CCNT_W-1:0]         n_removed, n_added, nm, ecount;
  logic [PCNT_W-1:0]         n_pairs, pptr;
  logic [MAX_CANDIDATES-1:0] rused, aused, emitted;
  logic                      pv, mv;
  logic [CCNT_W-1:0]         mptr;
  logic [CIDX_W-1:0]         mptr_d;

  // best pair of the current matching scan
  logic                      bfound;
  logic [gpm_pkg::KEY_W-1:0] bkey;

  // best entry of the current emit scan
  logic                      sfound;
  logic [CIDX_W-1:0]         sidx;
  logic [HW-1:0]             shash;
  logic [KW-1:0]             skind;
  logic [IW-1:0]             sadd;
  logic [DW-1:0]             sdist;
  logic [HW-1:0]             ahash;

  // --------------------------------------------------------------------------
  // memories and divider
  // --------------------------------------------------------------------------
  logic                      rem_we, add_we, pair_we, mb_we;
  logic [CIDX_W-1:0]         rem_raddr, add_raddr, mb_raddr;
  logic [RW-1:0]             rem_rdata;
  logic [HW-1:0]             add_rdata;
  logic [gpm_pkg::KEY_W-1:0] pair_rdata;
  logic [MW-1:0]             mb_rdata, mb_wdata;

  gpm_ram #(.W(RW), .D(MAX_CANDIDATES), .AW(CIDX_W)) u_rem_ram (
    .clk, .we(rem_we), .waddr(n_removed[CIDX_W-1:0]),
    .wdata({geom_kind, entry_hash[HW-1:0]}), .raddr(rem_raddr), .rdata(rem_rdata)
  );

  gpm_ram #(.W(HW), .D(MAX_CANDIDATES), .AW(CIDX_W)) u_add_ram (
    .clk, .we(add_we), .waddr(n_added[CIDX_W-1:0]),
    .wdata(entry_hash[HW-1:0]), .raddr(add_raddr), .rdata(add_rdata)
  );

  gpm_ram #(.W(gpm_pkg::KEY_W), .D(MAX_PAIRS), .AW(PIDX_W)) u_pair_ram (
    .clk, .we(pair_we), .waddr(n_pairs[PIDX_W-1:0]),
    .wdata({distance, removed_idx, added_idx}), .raddr(pptr[PIDX_W-1:0]),
    .rdata(pair_rdata)
  );

  gpm_ram #(.W(MW), .D(MAX_CANDIDATES), .AW(CIDX_W)) u_match_ram (
    .clk, .we(mb_we), .waddr(nm[CIDX_W-1:0]), .wdata(mb_wdata),
    .raddr(mb_raddr), .rdata(mb_rdata)
  );

  logic                        div_start, div_busy;
  logic [gpm_pkg::DIVN_W-1:0]  div_num;
  logic [gpm_pkg::TOL_W-1:0]   div_den;
  logic [gpm_pkg::CONF_W-1:0]  div_quo;

  gpm_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  // --------------------------------------------------------------------------
  // combinational decode
  // --------------------------------------------------------------------------
  logic                      in_acc, out_free, out_load, scan_done, sort_done, is_last;
  logic [IW-1:0]             p_r, p_a;
  logic                      p_ok;
  logic [HW-1:0]             m_hash;
  logic                      m_ok;
  logic [gpm_pkg::TOL_W-1:0] tol;
  logic [IW-1:0]             b_r, b_a;

  always_comb begin
    in_acc   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
    // a new result enters the output register this cycle
    out_load = ((state == gpm_pkg::S_EMIT) || (state == gpm_pkg::S_EMPTY)) && out_free;

    p_r = pair_rdata[2*IW-1:IW];
    p_a = pair_rdata[IW-1:0];
    // pair is usable when both ends are loaded and still unused
    p_ok = (32'(p_r) < 32'(n_removed)) && (32'(p_a) < 32'(n_added)) &&
           !rused[p_r[CIDX_W-1:0]] && !aused[p_a[CIDX_W-1:0]];

    m_hash = mb_rdata[MW-1 -: HW];
    m_ok   = !emitted[mptr_d] && (!sfound || (m_hash < shash));

    b_r = bkey[2*IW-1:IW];
    b_a = bkey[IW-1:0];

    scan_done = (pptr == n_pairs) && !pv;
    sort_done = (mptr == nm) && !mv;
    is_last   = (ecount + CCNT_W'(1)) == nm;

    if (skind <= gpm_pkg::KIND_POINT_LAST) begin
      tol = point_tol;
    end else if (skind <= gpm_pkg::KIND_LINE_LAST) begin
      tol = line_tol;
    end else begin
      tol = area_tol;
    end
    if ((tol != '0) && (sdist < tol)) begin
      div_num = {tol - sdist, {gpm_pkg::FRAC_W{1'b0}}};
    end else begin
      div_num = '0;
    end
    div_den = (tol == '0) ? gpm_pkg::TOL_W'(1) : tol;

    rem_we    = in_acc && (op == gpm_pkg::OP_LOAD_REMOVED) &&
                (n_removed < CCNT_W'(MAX_CANDIDATES));
    add_we    = in_acc && (op == gpm_pkg::OP_LOAD_ADDED) &&
                (n_added < CCNT_W'(MAX_CANDIDATES));
    pair_we   = in_acc && (op == gpm_pkg::OP_LOAD_PAIR) &&
                (n_pairs < PCNT_W'(MAX_PAIRS));
    mb_we     = (state == gpm_pkg::S_ACC2) && (nm < CCNT_W'(MAX_CANDIDATES));
    mb_wdata  = {rem_rdata[HW-1:0], rem_rdata[RW-1 -: KW], b_a, bkey[gpm_pkg::KEY_W-1 -: DW]};
    rem_raddr = b_r[CIDX_W-1:0];
    add_raddr = sadd[CIDX_W-1:0];
    mb_raddr  = mptr[CIDX_W-1:0];
    div_start = (state == gpm_pkg::S_DIVST);
    in_stall  = (state != gpm_pkg::S_IDLE);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gpm_pkg::S_IDLE: begin
        if (in_acc && (op == gpm_pkg::OP_RUN)) state_next = gpm_pkg::S_FIND;
      end
      gpm_pkg::S_FIND: begin
        if (scan_done) begin
          if (bfound)         state_next = gpm_pkg::S_ACC;
          else if (nm == '0)  state_next = gpm_pkg::S_EMPTY;
          else                state_next = gpm_pkg::S_SORT;
        end
      end
      gpm_pkg::S_ACC:   state_next = gpm_pkg::S_ACC2;
      gpm_pkg::S_ACC2:  state_next = gpm_pkg::S_FIND;
      gpm_pkg::S_SORT: begin
        if (sort_done) state_next = gpm_pkg::S_ADDR;
      end
      gpm_pkg::S_ADDR:  state_next = gpm_pkg::S_DIVST;
      gpm_pkg::S_DIVST: state_next = gpm_pkg::S_DIV;
      gpm_pkg::S_DIV: begin
        if (!div_busy) state_next = gpm_pkg::S_EMIT;
      end
      gpm_pkg::S_EMIT: begin
        if (out_free) state_next = is_last ? gpm_pkg::S_IDLE : gpm_pkg::S_SORT;
      end
      gpm_pkg::S_EMPTY: begin
        if (out_free) state_next = gpm_pkg::S_IDLE;
      end
      default: state_next = gpm_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      point_tol <= gpm_pkg::TOL_RESET;
      line_tol  <= gpm_pkg::TOL_RESET;
      area_tol  <= gpm_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpm_pkg::REG_POINT_TOL: point_tol <= cfg_data;
        gpm_pkg::REG_LINE_TOL:  line_tol  <= cfg_data;
        gpm_pkg::REG_AREA_TOL:  area_tol  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      n_removed <= '0;
      n_added   <= '0;
      n_pairs   <= '0;
      rused     <= '0;
      aused     <= '0;
      emitted   <= '0;
      nm        <= '0;
      ecount    <= '0;
      pptr      <= '0;
      mptr      <= '0;
      pv        <= 1'b0;
      mv        <= 1'b0;
      bfound    <= 1'b0;
      sfound    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop the output once the receiver takes it, unless a new one replaces it
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;

      unique case (state)
        gpm_pkg::S_IDLE: begin
          if (rem_we)  n_removed <= n_removed + CCNT_W'(1);
          if (add_we)  n_added   <= n_added + CCNT_W'(1);
          if (pair_we) n_pairs   <= n_pairs + PCNT_W'(1);
          pptr   <= '0;
          pv     <= 1'b0;
          bfound <= 1'b0;
        end
        gpm_pkg::S_FIND: begin
          // issue one pair read a cycle, compare the one that returns
          if (pptr != n_pairs) begin
            pptr <= pptr + PCNT_W'(1);
            pv   <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && p_ok && (!bfound || (pair_rdata < bkey))) begin
            bfound <= 1'b1;
            bkey   <= pair_rdata;
          end
          mptr   <= '0;
          mv     <= 1'b0;
          sfound <= 1'b0;
        end
        gpm_pkg::S_ACC: begin
          rused[b_r[CIDX_W-1:0]] <= 1'b1;
          aused[b_a[CIDX_W-1:0]] <= 1'b1;
        end
        gpm_pkg::S_ACC2: begin
          if (mb_we) nm <= nm + CCNT_W'(1);
          pptr   <= '0;
          pv     <= 1'b0;
          bfound <= 1'b0;
        end
        gpm_pkg::S_SORT: begin
          // smallest removed hash among entries not yet sent; first wins ties
          if (mptr != nm) begin
            mptr   <= mptr + CCNT_W'(1);
            mptr_d <= mptr[CIDX_W-1:0];
            mv     <= 1'b1;
          end else begin
            mv <= 1'b0;
          end
          if (mv && m_ok) begin
            sfound <= 1'b1;
            sidx   <= mptr_d;
            {shash, skind, sadd, sdist} <= mb_rdata;
          end
        end
        gpm_pkg::S_ADDR: ;
        gpm_pkg::S_DIVST: begin
          ahash <= add_rdata;
        end
        gpm_pkg::S_DIV: ;
        gpm_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            valid_pair       <= 1'b1;
            removed_hash_out <= gpm_pkg::HASH_PORT_W'(shash);
            added_hash_out   <= gpm_pkg::HASH_PORT_W'(ahash);
            match_distance   <= sdist;
            confidence       <= div_quo;
            last             <= is_last;
            mptr             <= '0;
            mv               <= 1'b0;
            sfound           <= 1'b0;
            if (is_last) begin
              n_removed <= '0;
              n_added   <= '0;
              n_pairs   <= '0;
              rused     <= '0;
              aused     <= '0;
              emitted   <= '0;
              nm        <= '0;
              ecount    <= '0;
            end else begin
              emitted[sidx] <= 1'b1;
              ecount        <= ecount + CCNT_W'(1);
            end
          end
        end
        gpm_pkg::S_EMPTY: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            valid_pair       <= 1'b0;
            removed_hash_out <= '0;
            added_hash_out   <= '0;
            match_distance   <= '0;
            confidence       <= '0;
            last             <= 1'b1;
            n_removed        <= '0;
            n_added          <= '0;
            n_pairs          <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    (state != gpm_pkg::S_ACC2) |-> ($countones(rused) == 32'(nm)))
    else $error("removed used map disagrees with match count");

  a_used_sides: assert property (@(posedge clk) disable iff (rst)
    $countones(rused) == $countones(aused))
    else $error("used maps of the two sides differ in size");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_pair) |-> last)
    else $error("empty-run item without last");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == gpm_pkg::S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");
`endif

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the greedy pair matcher
// A short table of directed loads and runs comes first. Random batches of
// loads follow, each one closed by a run. Tolerances are rewritten between
// batches while the block is idle. Every result transfer is checked against
// a typed result from the table or an in-bench predictor of the sort, the
// greedy match, the confidence and the hash-ordered emit.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAND_CAP   = gpm_pkg::MAX_CANDIDATES_DEF;
  localparam int PAIR_CAP   = gpm_pkg::MAX_PAIRS_DEF;
  localparam int ITEM_GOAL  = 480;
  localparam int CYCLE_CAP  = 1000000;
  localparam int N_ROWS     = 21;
  localparam int HW         = gpm_pkg::HASH_PORT_W;
  localparam int DW         = gpm_pkg::DIST_W;
  localparam int CW         = gpm_pkg::CONF_W;
  localparam int KW         = gpm_pkg::KIND_W;
  localparam int IW         = gpm_pkg::IDX_W;
  localparam int TW         = gpm_pkg::TOL_W;
  localparam int KEYW       = gpm_pkg::KEY_W;

  // One expected result transfer.
  typedef struct packed {
    logic          vp;
    logic [HW-1:0] rh;
    logic [HW-1:0] ah;
    logic [DW-1:0] mdist;
    logic [CW-1:0] conf;
    logic          lst;
  } match_t;

  // One row of the directed table.
  typedef struct packed {
    gpm_pkg::op_t  op;
    logic [KW-1:0] kind;
    logic [HW-1:0] hash;
    logic [DW-1:0] mdist;
    logic [IW-1:0] ri;
    logic [IW-1:0] ai;
    logic          typed;
    match_t        res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [gpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [TW-1:0]                 cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    op = '0;
  logic [KW-1:0]                 geom_kind = '0;
  logic [HW-1:0]                 entry_hash = '0;
  logic [DW-1:0]                 distance = '0;
  logic [IW-1:0]                 removed_idx = '0;
  logic [IW-1:0]                 added_idx = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          valid_pair;
  logic [HW-1:0]                 removed_hash_out;
  logic [HW-1:0]                 added_hash_out;
  logic [DW-1:0]                 match_distance;
  logic [CW-1:0]                 confidence;
  logic                          last;

  greedy_pair_matcher dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .geom_kind(geom_kind),
    .entry_hash(entry_hash), .distance(distance), .removed_idx(removed_idx),
    .added_idx(added_idx),
    .out_valid(out_valid), .out_stall(out_stall), .valid_pair(valid_pair),
    .removed_hash_out(removed_hash_out), .added_hash_out(added_hash_out),
    .match_distance(match_distance), .confidence(confidence), .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow state of the block: loaded stores and tolerances.
  logic [KW+HW-1:0] removed_list [$];
  logic [HW-1:0]    added_list [$];
  logic [KEYW-1:0]  pair_list [$];
  logic [TW-1:0] tol_point = gpm_pkg::TOL_RESET;
  logic [TW-1:0] tol_line  = gpm_pkg::TOL_RESET;
  logic [TW-1:0] tol_area  = gpm_pkg::TOL_RESET;

  match_t pending_matches [$];
  int errors = 0;
  int items_sent = 0;
  int runs_done = 0;
  int results_seen = 0;
  int cycles = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  function automatic logic [CW-1:0] conf_of(logic [DW-1:0] d, logic [TW-1:0] tol);
    logic [63:0] num;
    if (tol == '0 || d >= tol) return '0;
    num = 64'(tol - d) << gpm_pkg::FRAC_W;
    return CW'(num / 64'(tol));
  endfunction

  function automatic logic [TW-1:0] tol_of(logic [KW-1:0] kind);
    if (kind <= gpm_pkg::KIND_POINT_LAST) return tol_point;
    if (kind <= gpm_pkg::KIND_LINE_LAST) return tol_line;
    return tol_area;
  endfunction

  // Sort the pair keys, take pairs greedily, order the matches by removed
  // hash (stable), queue the results and clear the shadow stores.
  task automatic predict_run();
    logic [KEYW-1:0] keys [PAIR_CAP];
    logic [KEYW-1:0] hits [CAND_CAP];
    logic [KEYW-1:0] k;
    logic [CAND_CAP-1:0] rused;
    logic [CAND_CAP-1:0] aused;
    logic [HW-1:0] h;
    logic [KW+HW-1:0] rs;
    match_t m;
    int n, nm, i, j, r, a;
    n = pair_list.size();
    for (i = 0; i < n; i++) keys[i] = pair_list[i];
    for (i = 1; i < n; i++) begin
      k = keys[i];
      j = i;
      while (j > 0 && keys[j-1] > k) begin
        keys[j] = keys[j-1];
        j--;
      end
      keys[j] = k;
    end
    rused = '0;
    aused = '0;
    nm = 0;
    for (i = 0; i < n; i++) begin
      k = keys[i];
      r = int'(k[2*IW-1:IW]);
      a = int'(k[IW-1:0]);
      if (r >= removed_list.size() || a >= added_list.size()) continue;
      if (rused[r] || aused[a]) continue;
      rused[r] = 1'b1;
      aused[a] = 1'b1;
      hits[nm] = k;
      nm++;
    end
    for (i = 1; i < nm; i++) begin
      k = hits[i];
      h = removed_list[k[2*IW-1:IW]][HW-1:0];
      j = i;
      while (j > 0 && removed_list[hits[j-1][2*IW-1:IW]][HW-1:0] > h) begin
        hits[j] = hits[j-1];
        j--;
      end
      hits[j] = k;
    end
    if (nm == 0) begin
      m = '0;
      m.lst = 1'b1;
      pending_matches.insert(pending_matches.size(), m);
    end
    for (i = 0; i < nm; i++) begin
      rs = removed_list[hits[i][2*IW-1:IW]];
      m.vp    = 1'b1;
      m.rh    = rs[HW-1:0];
      m.ah    = added_list[hits[i][IW-1:0]];
      m.mdist = hits[i][KEYW-1:2*IW];
      m.conf  = conf_of(m.mdist, tol_of(rs[KW+HW-1:HW]));
      m.lst   = (i == nm - 1);
      pending_matches.insert(pending_matches.size(), m);
    end
    removed_list.delete();
    added_list.delete();
    pair_list.delete();
  endtask

  // Present one item after a random gap, or none when calm, and hold it until the transfer.
  task automatic send(gpm_pkg::op_t o, logic [KW-1:0] kd, logic [HW-1:0] hs,
                      logic [DW-1:0] ds, logic [IW-1:0] ri, logic [IW-1:0] ai,
                      logic typed, match_t res);
    int gap;
    gap = calm_in ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= o;
    geom_kind <= kd;
    entry_hash <= hs;
    distance <= ds;
    removed_idx <= ri;
    added_idx <= ai;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    case (o)
      gpm_pkg::OP_LOAD_REMOVED:
        if (removed_list.size() < CAND_CAP) removed_list.insert(removed_list.size(), {kd, hs});
      gpm_pkg::OP_LOAD_ADDED:
        if (added_list.size() < CAND_CAP) added_list.insert(added_list.size(), hs);
      gpm_pkg::OP_LOAD_PAIR:
        if (pair_list.size() < PAIR_CAP) pair_list.insert(pair_list.size(), {ds, ri, ai});
      default: begin
        runs_done++;
        if (typed) begin
          pending_matches.insert(pending_matches.size(), res);
          removed_list.delete();
          added_list.delete();
          pair_list.delete();
        end else begin
          predict_run();
        end
      end
    endcase
  endtask

  // Drop valid, wait for every queued result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(gpm_pkg::reg_idx_t idx, logic [TW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gpm_pkg::REG_POINT_TOL: tol_point = val;
      gpm_pkg::REG_LINE_TOL:  tol_line = val;
      gpm_pkg::REG_AREA_TOL:  tol_area = val;
      default: ;
    endcase
  endtask

  function automatic logic [TW-1:0] pick_tol();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TW'(1);
      2: return '1;
      3: return gpm_pkg::TOL_RESET;
      4: return TW'($urandom_range(0, 400));
      default: return TW'($urandom());
    endcase
  endfunction

  function automatic logic [HW-1:0] pick_hash();
    // Half the hashes come from a tiny pool so that equal hashes occur.
    if ($urandom_range(0, 1) == 0) return HW'($urandom_range(0, 7));
    return HW'({$urandom(), $urandom()});
  endfunction

  // Directed table: extremes, ties, out-of-range pairs and empty runs.
  // Typed results are the ones that can be read off directly.
  localparam logic [HW-1:0] HALL = '1;
  localparam logic [DW-1:0] DALL = '1;
  localparam logic [TW-1:0] TALL = '1;
  localparam match_t NO_RES    = '0;
  localparam match_t EMPTY_RES = '{1'b0, '0, '0, '0, '0, 1'b1};
  row_t dir_rows [N_ROWS];

  initial begin
    dir_rows[0]  = '{gpm_pkg::OP_RUN, 3'd5, HALL, DALL, 6'd63, 6'd63, 1'b1, EMPTY_RES};
    dir_rows[1]  = '{gpm_pkg::OP_LOAD_REMOVED, 3'd0, HALL, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[2]  = '{gpm_pkg::OP_LOAD_ADDED, 3'd7, '0, DALL, 6'd63, 6'd63, 1'b0, NO_RES};
    dir_rows[3]  = '{gpm_pkg::OP_LOAD_PAIR, 3'd7, HALL, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[4]  = '{gpm_pkg::OP_RUN, '0, '0, '0, '0, '0, 1'b1,
                     '{1'b1, HALL, '0, '0, 17'd65536, 1'b1}};
    dir_rows[5]  = '{gpm_pkg::OP_LOAD_REMOVED, 3'd7, 48'd5, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[6]  = '{gpm_pkg::OP_LOAD_ADDED, '0, HALL, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[7]  = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, DALL, '0, '0, 1'b0, NO_RES};
    dir_rows[8]  = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd5, 6'd63, 6'd63, 1'b0, NO_RES};
    dir_rows[9]  = '{gpm_pkg::OP_RUN, '0, '0, '0, '0, '0, 1'b1,
                     '{1'b1, 48'd5, HALL, DALL, 17'd0, 1'b1}};
    dir_rows[10] = '{gpm_pkg::OP_LOAD_REMOVED, 3'd3, 48'd10, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[11] = '{gpm_pkg::OP_LOAD_REMOVED, 3'd1, 48'd3, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[12] = '{gpm_pkg::OP_LOAD_ADDED, '0, 48'd7, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[13] = '{gpm_pkg::OP_LOAD_ADDED, '0, 48'd8, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[14] = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd50, 6'd1, 6'd0, 1'b0, NO_RES};
    dir_rows[15] = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd50, 6'd0, 6'd0, 1'b0, NO_RES};
    dir_rows[16] = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd70, 6'd1, 6'd1, 1'b0, NO_RES};
    dir_rows[17] = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd20, 6'd2, 6'd1, 1'b0, NO_RES};
    dir_rows[18] = '{gpm_pkg::OP_RUN, '0, '0, '0, '0, '0, 1'b0, NO_RES};
    dir_rows[19] = '{gpm_pkg::OP_LOAD_PAIR, '0, '0, 24'd1, '0, '0, 1'b0, NO_RES};
    dir_rows[20] = '{gpm_pkg::OP_RUN, '0, '0, '0, '0, '0, 1'b1, EMPTY_RES};
  end

  // Stimulus.
  initial begin
    int phase, nr, na, np, pick, i, left;
    bit big_done;
    logic [IW-1:0] ri, ai;
    logic [DW-1:0] ds;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    for (i = 0; i < N_ROWS; i++)
      send(dir_rows[i].op, dir_rows[i].kind, dir_rows[i].hash, dir_rows[i].mdist,
           dir_rows[i].ri, dir_rows[i].ai, dir_rows[i].typed, dir_rows[i].res);
    // Hold off the sender until every run result has come back.
    drain();

    phase = 0;
    big_done = 1'b0;
    while (items_sent < ITEM_GOAL + N_ROWS) begin
      // Block is idle here: retune the tolerances.
      write_reg(gpm_pkg::REG_POINT_TOL, (phase == 0) ? TW'(0) : pick_tol());
      write_reg(gpm_pkg::REG_LINE_TOL, (phase == 0) ? TALL : pick_tol());
      write_reg(gpm_pkg::REG_AREA_TOL, (phase == 0) ? TW'(1) : pick_tol());
      if ($urandom_range(0, 3) == 0) write_reg(gpm_pkg::REG_NONE, TW'($urandom()));
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);

      if (phase == 3 && !big_done) begin
        // Overfill both candidate stores once, then run a large case.
        big_done = 1'b1;
        for (i = 0; i < CAND_CAP + 2; i++)
          send(gpm_pkg::OP_LOAD_REMOVED, KW'($urandom()), pick_hash(), '0, '0, '0,
               1'b0, NO_RES);
        for (i = 0; i < CAND_CAP + 2; i++)
          send(gpm_pkg::OP_LOAD_ADDED, '0, pick_hash(), '0, '0, '0, 1'b0, NO_RES);
        for (i = 0; i < 2 * CAND_CAP; i++)
          send(gpm_pkg::OP_LOAD_PAIR, '0, '0, DW'($urandom_range(0, 200)),
               IW'($urandom()), IW'($urandom()), 1'b0, NO_RES);
      end else if ($urandom_range(0, 9) == 0) begin
        // Noise: loads in any order with any fields.
        for (i = 0; i < 12; i++)
          send(gpm_pkg::op_t'($urandom_range(0, 2)), KW'($urandom()),
               HW'({$urandom(), $urandom()}), DW'($urandom()), IW'($urandom()),
               IW'($urandom()), 1'b0, NO_RES);
      end else begin
        nr = $urandom_range(0, 6);
        na = $urandom_range(0, 6);
        np = $urandom_range(0, 12);
        left = nr + na + np;
        while (left > 0) begin
          // Interleave the loads; indices refer to counts at run time.
          pick = $urandom_range(1, left);
          ri = (nr > 0 && $urandom_range(0, 3) != 0) ? IW'($urandom_range(0, nr - 1))
                                                      : IW'($urandom());
          ai = (na > 0 && $urandom_range(0, 3) != 0) ? IW'($urandom_range(0, na - 1))
                                                      : IW'($urandom());
          ds = ($urandom_range(0, 7) == 0) ? DW'($urandom())
                                           : DW'($urandom_range(0, 250));
          if (pick <= nr && nr > 0) begin
            send(gpm_pkg::OP_LOAD_REMOVED, KW'($urandom()), pick_hash(), DW'($urandom()),
                 IW'($urandom()), IW'($urandom()), 1'b0, NO_RES);
            nr--;
          end else if (pick <= nr + na && na > 0) begin
            send(gpm_pkg::OP_LOAD_ADDED, KW'($urandom()), pick_hash(), DW'($urandom()),
                 IW'($urandom()), IW'($urandom()), 1'b0, NO_RES);
            na--;
          end else begin
            send(gpm_pkg::OP_LOAD_PAIR, KW'($urandom()), HW'({$urandom(), $urandom()}),
                 ds, ri, ai, 1'b0, NO_RES);
            np--;
          end
          left = nr + na + np;
        end
      end
      send(gpm_pkg::OP_RUN, KW'($urandom()), HW'({$urandom(), $urandom()}),
           DW'($urandom()), IW'($urandom()), IW'($urandom()), 1'b0, NO_RES);
      drain();
      phase++;
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d items in %0d runs, %0d result transfers checked.",
             items_sent, runs_done, results_seen);
    $display("Tolerance extremes, store overflow and stalls on both channels included.");
    if (errors == 0 && pending_matches.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Result side: check each transfer, then draw the stall for the next one.
  int stall_left = 0;
  always @(posedge clk) begin
    match_t m;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (pending_matches.size() == 0) begin
        $error("result transfer with no expectation waiting");
        errors++;
      end else begin
        m = pending_matches.pop_front();
        if (valid_pair !== m.vp) begin
          $error("valid_pair expected %0d got %0d", m.vp, valid_pair);
          errors++;
        end
        if (removed_hash_out !== m.rh) begin
          $error("removed_hash_out expected %h got %h", m.rh, removed_hash_out);
          errors++;
        end
        if (added_hash_out !== m.ah) begin
          $error("added_hash_out expected %h got %h", m.ah, added_hash_out);
          errors++;
        end
        if (match_distance !== m.mdist) begin
          $error("match_distance expected %0d got %0d", m.mdist, match_distance);
          errors++;
        end
        if (confidence !== m.conf) begin
          $error("confidence expected %0d got %0d", m.conf, confidence);
          errors++;
        end
        if (last !== m.lst) begin
          $error("last expected %0d got %0d", m.lst, last);
          errors++;
        end
      end
      stall_left = calm_out ? 0 : int'($urandom_range(0, 7));
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule
